>>> rtl/core/full_period_lcg_generator_core_macros.svh
// Assertion macros for the full-period LCG core.
// Expects clk and rst_n in the scope of each use; NO_ASSERTIONS removes all checks.
`ifndef FULL_PERIOD_LCG_GENERATOR_CORE_MACROS_SVH
`define FULL_PERIOD_LCG_GENERATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FPLG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FPLG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FPLG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPLG_ASSERT(name, prop, msg)
`define FPLG_ASSERT_IMP(name, ante, cons, msg)
`define FPLG_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

>>> rtl/core/fplg_pkg.sv
// Shared widths, microcode encoding and control ROM of the full-period LCG core.
// No dependencies.
package fplg_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int VAL_W  = 16;          // value / position field width
  localparam int M_W    = VAL_W + 1;   // modulus, a, c, radical
  localparam int PROD_W = 2 * M_W;     // product and dividend width
  localparam int UPC_W  = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // datapath operations
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_ACCEPT  = 4'd1;
  localparam logic [3:0] OP_FINIT   = 4'd2;
  localparam logic [3:0] OP_SQ      = 4'd3;
  localparam logic [3:0] OP_DIVF    = 4'd4;
  localparam logic [3:0] OP_RADP    = 4'd5;
  localparam logic [3:0] OP_SETRAD  = 4'd6;
  localparam logic [3:0] OP_NEXTP   = 4'd7;
  localparam logic [3:0] OP_FIN     = 4'd8;
  localparam logic [3:0] OP_PARAMS  = 4'd9;
  localparam logic [3:0] OP_RESTART = 4'd10;
  localparam logic [3:0] OP_EMIT    = 4'd11;
  localparam logic [3:0] OP_GENADD  = 4'd12;
  localparam logic [3:0] OP_DIVG    = 4'd13;
  localparam logic [3:0] OP_NEWX    = 4'd14;
  localparam logic [3:0] OP_CLRX    = 4'd15;

  // hold conditions: step repeats, op suppressed
  localparam logic [1:0] HOLD_NONE  = 2'd0;
  localparam logic [1:0] HOLD_NO_IN = 2'd1;
  localparam logic [1:0] HOLD_DIV   = 2'd2;
  localparam logic [1:0] HOLD_OUT   = 2'd3;

  // jump conditions
  localparam logic [2:0] J_NEXT    = 3'd0;
  localparam logic [2:0] J_ALWAYS  = 3'd1;
  localparam logic [2:0] J_PARAMS  = 3'd2;
  localparam logic [2:0] J_PROD_GT = 3'd3;
  localparam logic [2:0] J_REM_NZ  = 3'd4;
  localparam logic [2:0] J_LAST    = 3'd5;

  // program steps
  localparam upc_t S_IDLE   = 5'd0;
  localparam upc_t S_FINIT  = 5'd1;
  localparam upc_t S_SQ     = 5'd2;
  localparam upc_t S_TST    = 5'd3;
  localparam upc_t S_DIVF   = 5'd4;
  localparam upc_t S_DWF    = 5'd5;
  localparam upc_t S_RADP   = 5'd6;
  localparam upc_t S_SETRAD = 5'd7;
  localparam upc_t S_NEXTP  = 5'd8;
  localparam upc_t S_FIN    = 5'd9;
  localparam upc_t S_PARAMS = 5'd10;
  localparam upc_t S_GEN    = 5'd11;
  localparam upc_t S_EMIT   = 5'd12;
  localparam upc_t S_GENADD = 5'd13;
  localparam upc_t S_DIVG   = 5'd14;
  localparam upc_t S_DWG    = 5'd15;
  localparam upc_t S_CLRX   = 5'd16;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] hold;
    logic [2:0] jmp;
    upc_t       target;
  } uword_t;

  function automatic uword_t upc_rom(input upc_t pc);
    uword_t w;
    case (pc)
      S_IDLE:   w = '{op: OP_ACCEPT,  hold: HOLD_NO_IN, jmp: J_PARAMS,  target: S_GEN};
      S_FINIT:  w = '{op: OP_FINIT,   hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_SQ:     w = '{op: OP_SQ,      hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_TST:    w = '{op: OP_NOP,     hold: HOLD_NONE,  jmp: J_PROD_GT, target: S_FIN};
      S_DIVF:   w = '{op: OP_DIVF,    hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_DWF:    w = '{op: OP_NOP,     hold: HOLD_DIV,   jmp: J_REM_NZ,  target: S_NEXTP};
      S_RADP:   w = '{op: OP_RADP,    hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_SETRAD: w = '{op: OP_SETRAD,  hold: HOLD_NONE,  jmp: J_ALWAYS,  target: S_DIVF};
      S_NEXTP:  w = '{op: OP_NEXTP,   hold: HOLD_NONE,  jmp: J_ALWAYS,  target: S_SQ};
      S_FIN:    w = '{op: OP_FIN,     hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_PARAMS: w = '{op: OP_PARAMS,  hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_GEN:    w = '{op: OP_RESTART, hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_EMIT:   w = '{op: OP_EMIT,    hold: HOLD_OUT,   jmp: J_LAST,    target: S_CLRX};
      S_GENADD: w = '{op: OP_GENADD,  hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_DIVG:   w = '{op: OP_DIVG,    hold: HOLD_NONE,  jmp: J_NEXT,    target: S_IDLE};
      S_DWG:    w = '{op: OP_NEWX,    hold: HOLD_DIV,   jmp: J_ALWAYS,  target: S_IDLE};
      S_CLRX:   w = '{op: OP_CLRX,    hold: HOLD_NONE,  jmp: J_ALWAYS,  target: S_IDLE};
      default:  w = '{op: OP_NOP,     hold: HOLD_NONE,  jmp: J_ALWAYS,  target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/fplg_div.sv
// Restoring divider, one quotient bit per cycle; shared by factoring and modulo.
// Depends on fplg_pkg (default widths) and the core macros header.
`include "full_period_lcg_generator_core_macros.svh"

module fplg_div
  import fplg_pkg::*;
#(
  parameter int DVD_W = PROD_W,
  parameter int DVS_W = M_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quo,
  output logic [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rem_r <= '0;
      dvs_r <= DVS_W'(1);
      quo_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
      dvs_r <= dvs_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = cnt_r != '0;
  assign quo  = quo_r;
  assign rem  = rem_r;

  logic rem_ok;
  assign rem_ok = rem_r < dvs_r;

  `FPLG_ASSERT_IMP(a_div_rem_below_divisor, !busy, rem_ok, "divider remainder not reduced")
  `FPLG_ASSERT_NXT(a_div_start_busy, start, busy, "divider did not start")
  `FPLG_ASSERT_NXT(a_div_count_down, busy && !start, cnt_r == $past(cnt_r) - CNT_W'(1),
                   "divider count skipped")

endmodule

>>> rtl/core/full_period_lcg_generator_core.sv
// Full-period LCG core: microcoded sequencer, shared multiplier and divider.
// Depends on fplg_pkg, fplg_div and the core macros header.
//
// Each request returns one value of x(n+1) = (a*x(n) + c) mod m with m = max_value + 1,
// starting at 0; position counts within the period and last_of_period marks the
// m-th value, after which the sequence starts again at 0. The modulo of each request
// runs on the bit-serial divider. The first request after reset or a max_value write
// also factors m by trial division through the same divider, with trial divisors
// up to sqrt(m) (at most 256 for 16 bits).
// A finished value waits in the output register while the next request runs.
`include "full_period_lcg_generator_core_macros.svh"

module full_period_lcg_generator_core
  import fplg_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] cfg_max_value,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_restart,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_value,
  output logic [VAL_W-1:0] out_position,
  output logic             out_last_of_period
);

  localparam int KEEP_BITS = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam logic [M_W-1:0] KEEP_FULL = (M_W'(1) << KEEP_BITS) - M_W'(1);
  localparam logic [VAL_W-1:0] KEEP_MASK = KEEP_FULL[VAL_W-1:0];
  localparam logic [VAL_W-1:0] MAX_RESET = VAL_W'(255) & KEEP_MASK;

  upc_t              pc_r, pc_nxt;
  logic [VAL_W-1:0]  max_r, max_nxt;
  logic              restart_r, restart_nxt;
  logic              params_ready_r, params_ready_nxt;
  logic [VAL_W-1:0]  x_r, x_nxt;
  logic [M_W-1:0]    pos_r, pos_nxt;
  logic [M_W-1:0]    a_r, a_nxt;
  logic [M_W-1:0]    c_r, c_nxt;
  logic [M_W-1:0]    rest_r, rest_nxt;
  logic [M_W-1:0]    p_r, p_nxt;
  logic [M_W-1:0]    rad_r, rad_nxt;
  logic              used_r, used_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [VAL_W-1:0]  out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_valid_r, out_valid_nxt;

  uword_t            uw;
  logic              held;
  logic              take;
  logic [3:0]        op_x;
  logic [M_W-1:0]    m;
  logic              last;
  logic [M_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              cfg_wr;
  logic              div_start;
  logic [PROD_W-1:0] div_dvd;
  logic [M_W-1:0]    div_dvs;
  logic              div_busy;
  logic [PROD_W-1:0] div_quo;
  logic [M_W-1:0]    div_rem;

  assign m         = {1'b0, max_r} + M_W'(1);
  assign last      = ({1'b0, pos_r} + (M_W + 1)'(1)) >= {1'b0, m};
  assign cfg_ready = pc_r == S_IDLE;
  assign in_ready  = (pc_r == S_IDLE) && !cfg_valid;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // sequencer
  always_comb begin
    uw = upc_rom(pc_r);
    case (uw.hold)
      HOLD_NONE:  held = 1'b0;
      HOLD_NO_IN: held = !(in_valid && in_ready);
      HOLD_DIV:   held = div_busy;
      HOLD_OUT:   held = out_valid_r && !out_ready;
      default:    held = 1'b0;
    endcase
    case (uw.jmp)
      J_NEXT:    take = 1'b0;
      J_ALWAYS:  take = 1'b1;
      J_PARAMS:  take = params_ready_r;
      J_PROD_GT: take = prod_r > {{(PROD_W-M_W){1'b0}}, rest_r};
      J_REM_NZ:  take = div_rem != '0;
      J_LAST:    take = last;
      default:   take = 1'b0;
    endcase
    op_x   = held ? OP_NOP : uw.op;
    pc_nxt = held ? pc_r : (take ? uw.target : pc_r + upc_t'(1));
  end

  // shared multiplier
  always_comb begin
    case (op_x)
      OP_SQ: begin
        mul_a = p_r;
        mul_b = p_r;
      end
      OP_RADP: begin
        mul_a = rad_r;
        mul_b = p_r;
      end
      OP_FIN: begin
        mul_a = rad_r;
        mul_b = (rest_r > M_W'(1)) ? rest_r : M_W'(1);
      end
      OP_EMIT: begin
        mul_a = a_r;
        mul_b = {1'b0, x_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign div_start = (op_x == OP_DIVF) || (op_x == OP_DIVG);
  assign div_dvd   = (op_x == OP_DIVF) ? {{(PROD_W-M_W){1'b0}}, rest_r} : prod_r;
  assign div_dvs   = (op_x == OP_DIVF) ? p_r : m;

  fplg_div #(
    .DVD_W (PROD_W),
    .DVS_W (M_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // datapath
  always_comb begin
    max_nxt          = max_r;
    restart_nxt      = restart_r;
    params_ready_nxt = params_ready_r;
    x_nxt            = x_r;
    pos_nxt          = pos_r;
    a_nxt            = a_r;
    c_nxt            = c_r;
    rest_nxt         = rest_r;
    p_nxt            = p_r;
    rad_nxt          = rad_r;
    used_nxt         = used_r;
    prod_nxt         = prod_r;
    out_value_nxt    = out_value_r;
    out_pos_nxt      = out_pos_r;
    out_last_nxt     = out_last_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    case (op_x)
      OP_ACCEPT: restart_nxt = in_restart;
      OP_FINIT: begin
        rest_nxt = m;
        rad_nxt  = M_W'(1);
        p_nxt    = M_W'(2);
        used_nxt = 1'b0;
      end
      OP_SQ:     prod_nxt = mul_p;
      OP_RADP: begin
        rest_nxt = div_quo[M_W-1:0];
        prod_nxt = mul_p;
      end
      OP_SETRAD: begin
        // record each prime once
        if (!used_r) begin
          rad_nxt = prod_r[M_W-1:0];
        end
        used_nxt = 1'b1;
      end
      OP_NEXTP: begin
        p_nxt    = p_r + M_W'(1);
        used_nxt = 1'b0;
      end
      OP_FIN:    prod_nxt = mul_p;
      OP_PARAMS: begin
        a_nxt            = (m == M_W'(1)) ? M_W'(2) : m + M_W'(1);
        c_nxt            = prod_r[M_W-1:0] + M_W'(1);
        params_ready_nxt = 1'b1;
      end
      OP_RESTART: begin
        if (restart_r) begin
          x_nxt   = '0;
          pos_nxt = '0;
        end
      end
      OP_EMIT: begin
        out_value_nxt = x_r;
        out_pos_nxt   = pos_r[VAL_W-1:0];
        out_last_nxt  = last;
        out_valid_nxt = 1'b1;
        prod_nxt      = mul_p;
      end
      OP_GENADD: prod_nxt = prod_r + {{(PROD_W-M_W){1'b0}}, c_r};
      OP_NEWX: begin
        x_nxt   = div_rem[VAL_W-1:0];
        pos_nxt = pos_r + M_W'(1);
      end
      OP_CLRX: begin
        x_nxt   = '0;
        pos_nxt = '0;
      end
      default: ;
    endcase
    if (cfg_wr) begin
      max_nxt          = cfg_max_value & KEEP_MASK;
      params_ready_nxt = 1'b0;
      x_nxt            = '0;
      pos_nxt          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r           <= S_IDLE;
      max_r          <= MAX_RESET;
      params_ready_r <= 1'b0;
      x_r            <= '0;
      pos_r          <= '0;
      a_r            <= '0;
      c_r            <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      pc_r           <= pc_nxt;
      max_r          <= max_nxt;
      params_ready_r <= params_ready_nxt;
      x_r            <= x_nxt;
      pos_r          <= pos_nxt;
      a_r            <= a_nxt;
      c_r            <= c_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    restart_r   <= restart_nxt;
    rest_r      <= rest_nxt;
    p_r         <= p_nxt;
    rad_r       <= rad_nxt;
    used_r      <= used_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_position       = out_pos_r;
  assign out_last_of_period = out_last_r;

  logic x_ok, pos_ok, a_ok, last_ok;
  assign x_ok    = {1'b0, x_r} < m;
  assign pos_ok  = pos_r < m;
  assign a_ok    = (a_r == m + M_W'(1)) || ((m == M_W'(1)) && (a_r == M_W'(2)));
  assign last_ok = out_last_r == (({1'b0, out_pos_r} + M_W'(1)) >= m);

  `FPLG_ASSERT(a_x_in_range, x_ok, "state value not below modulus")
  `FPLG_ASSERT(a_pos_in_range, pos_ok, "position not below modulus")
  `FPLG_ASSERT_IMP(a_mult_matches, params_ready_r, a_ok, "multiplier does not match modulus")
  `FPLG_ASSERT_IMP(a_last_flag, $rose(out_valid_r), last_ok, "last flag wrong for position")
  `FPLG_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider restarted while busy")

endmodule
